// ===== rtl/spq_pkg.sv =====
package spq_pkg;

    typedef enum logic [1:0] {
        MODE_ENQUEUE = 2'd0,
        MODE_DEQUEUE = 2'd1,
        MODE_CLEAR   = 2'd2
    } mode_t;

    typedef struct packed {
        logic signed [31:0] value;
        logic signed [31:0] prio;
    } entry_t;

    // Broadcast from the top level to every cell for one accepted request
    typedef struct packed {
        logic   enq;
        logic   deq;
        entry_t item;
    } cell_ctrl_t;

endpackage

// ===== rtl/spq_in_if.sv =====
interface spq_in_if;
    import spq_pkg::*;

    logic               valid;
    logic               ready;
    logic [1:0]         mode;
    logic signed [31:0] item_value;
    logic signed [31:0] item_priority;

    modport source (output valid, output mode, output item_value, output item_priority,
                    input ready);
    modport sink   (input valid, input mode, input item_value, input item_priority,
                    output ready);
endinterface

// ===== rtl/spq_out_if.sv =====
interface spq_out_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] head_value;
    logic signed [31:0] head_priority;
    logic [4:0]         entry_count;
    logic               queue_empty;
    logic               dropped;

    modport source (output valid, output head_value, output head_priority,
                    output entry_count, output queue_empty, output dropped, input ready);
    modport sink   (input valid, input head_value, input head_priority,
                    input entry_count, input queue_empty, input dropped, output ready);
endinterface

// ===== rtl/stable_priority_queue_top.sv =====
// Stable priority queue, lowest priority number first, equal priorities in arrival order.
// req channel: one request per handshake, mode 0 enqueue, 1 dequeue head, 2 clear;
//   mode 3 changes nothing. item_value and item_priority matter for an enqueue only.
// rsp channel: one response per request, giving head, count and empty flag after the
//   operation, and dropped when an enqueue found the queue full.
// Storage is a row of DEPTH cells; on each request every cell compares its priority
// with the new one in parallel and either holds, takes the new entry, or takes its
// left or right neighbour's entry, so the whole insert or remove is done in all cells at once.
// Latency: the response is valid the cycle after the request is accepted.
// Throughput: one request per cycle while rsp is taken each cycle.
// Stall: while a response waits on rsp.ready, req.ready is low and the state holds;
//   a new request is taken in the same cycle the waiting response is taken.
// Reset: the queue is empty and no response is pending; cell contents are undefined
//   and are never shown, as only occupied cells reach the head output.
module stable_priority_queue_top
    import spq_pkg::*;
#(
    parameter int DEPTH = 16
)
(
    input  logic clk,
    input  logic rst_n,
    spq_in_if.sink    req,
    spq_out_if.source rsp
);

    localparam int CW = $clog2(DEPTH + 1);

    logic [CW-1:0] count_reg, count_next;
    logic          dropped_reg, dropped_next;
    logic          rsp_valid_reg;
    logic          accept;
    logic          full;
    cell_ctrl_t    ctrl;

    entry_t        cell_data [DEPTH];
    logic          cell_le   [DEPTH];

    assign req.ready = !rsp_valid_reg || rsp.ready;
    assign accept    = req.valid && req.ready;
    assign full      = (count_reg == CW'(DEPTH));

    assign ctrl.item.value = req.item_value;
    assign ctrl.item.prio  = req.item_priority;
    assign ctrl.enq = accept && (req.mode == MODE_ENQUEUE) && !full;
    assign ctrl.deq = accept && (req.mode == MODE_DEQUEUE) && (count_reg != '0);

    always_comb
    begin
        count_next   = count_reg;
        dropped_next = dropped_reg;
        if (accept)
        begin
            dropped_next = 1'b0;
            unique case (req.mode)
                MODE_ENQUEUE:
                begin
                    if (full)
                        dropped_next = 1'b1;
                    else
                        count_next = count_reg + CW'(1);
                end
                MODE_DEQUEUE:
                begin
                    if (count_reg != '0)
                        count_next = count_reg - CW'(1);
                end
                MODE_CLEAR:
                begin
                    count_next = '0;
                end
                default:
                begin
                    count_next = count_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            dropped_reg   <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg   <= count_next;
            dropped_reg <= dropped_next;
            if (accept)
                rsp_valid_reg <= 1'b1;
            else if (rsp.ready)
                rsp_valid_reg <= 1'b0;
        end
    end

    genvar i;
    generate
        for (i = 0; i < DEPTH; i++)
        begin : g_cell
            logic   occupied;
            logic   left_le;
            entry_t left_data;
            entry_t right_data;

            assign occupied = (CW'(i) < count_reg);

            if (i == 0)
            begin : g_first
                assign left_le   = 1'b1;
                assign left_data = ctrl.item;
            end
            else
            begin : g_inner
                assign left_le   = cell_le[i-1];
                assign left_data = cell_data[i-1];
            end

            if (i == DEPTH - 1)
            begin : g_last
                assign right_data = cell_data[i];
            end
            else
            begin : g_next
                assign right_data = cell_data[i+1];
            end

            spq_cell u_cell (
                .clk        (clk),
                .ctrl       (ctrl),
                .occupied   (occupied),
                .left_le    (left_le),
                .left_data  (left_data),
                .right_data (right_data),
                .data       (cell_data[i]),
                .le         (cell_le[i])
            );
        end
    endgenerate

    // The state only moves on an accepted request, so the head can be read straight
    // from cell 0 while a response is held
    assign rsp.valid         = rsp_valid_reg;
    assign rsp.head_value    = (count_reg != '0) ? cell_data[0].value : '0;
    assign rsp.head_priority = (count_reg != '0) ? cell_data[0].prio  : '0;
    assign rsp.entry_count   = 5'(count_reg);
    assign rsp.queue_empty   = (count_reg == '0);
    assign rsp.dropped       = dropped_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(DEPTH))
        else $error("count exceeds depth");

    a_drop_full: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid_reg && dropped_reg) |-> full)
        else $error("drop reported with room left");

    a_enq_count: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.enq |=> (count_reg == $past(count_reg) + CW'(1)))
        else $error("enqueue did not add one entry");

    a_head_order: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg >= CW'(2)) |-> (cell_data[0].prio <= cell_data[1].prio))
        else $error("head cells out of order");

endmodule

// ===== rtl/spq_cell.sv =====
module spq_cell
    import spq_pkg::*;
(
    input  logic       clk,
    input  cell_ctrl_t ctrl,
    input  logic       occupied,
    input  logic       left_le,
    input  entry_t     left_data,
    input  entry_t     right_data,
    output entry_t     data,
    output logic       le
);

    entry_t data_reg;
    entry_t data_next;

    // le forms a prefix of the chain because the entries are kept sorted
    assign le   = occupied && (data_reg.prio <= ctrl.item.prio);
    assign data = data_reg;

    always_comb
    begin
        data_next = data_reg;
        if (ctrl.enq)
        begin
            priority if (le)
                data_next = data_reg;
            else if (left_le)
                data_next = ctrl.item;
            else
                data_next = left_data;
        end
        else if (ctrl.deq)
        begin
            data_next = right_data;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

endmodule

// ===== bench/spq_checker.sv =====
module spq_checker
    import spq_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    spq_in_if    req,
    spq_out_if   rsp,
    output int   fail_count,
    output int   pending_count
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int QUEUE_DEPTH = 16;

    typedef struct {
        logic signed [31:0] value;
        logic signed [31:0] prio;
        logic [4:0]         count;
        logic               empty;
        logic               dropped;
    } head_report_t;

    logic signed [31:0] slot_val  [QUEUE_DEPTH];
    logic signed [31:0] slot_prio [QUEUE_DEPTH];
    int                 occupancy;
    head_report_t       pending_heads [$];

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("[%0t] mismatch on %s: got %0h, want %0h", $time, what, got, want);
        fail_count++;
    endtask

    // Sorted insert after every entry of lower or equal priority keeps ties in arrival order
    function automatic head_report_t apply_request(input logic [1:0] mode,
                                                   input logic signed [31:0] v,
                                                   input logic signed [31:0] p);
        head_report_t rep;
        int           pos;
        rep.dropped = 1'b0;
        case (mode)
            MODE_ENQUEUE:
            begin
                if (occupancy >= QUEUE_DEPTH)
                begin
                    rep.dropped = 1'b1;
                end
                else
                begin
                    pos = 0;
                    while (pos < occupancy && slot_prio[pos] <= p)
                        pos++;
                    for (int i = occupancy; i > pos; i--)
                    begin
                        slot_val[i]  = slot_val[i-1];
                        slot_prio[i] = slot_prio[i-1];
                    end
                    slot_val[pos]  = v;
                    slot_prio[pos] = p;
                    occupancy++;
                end
            end
            MODE_DEQUEUE:
            begin
                if (occupancy > 0)
                begin
                    for (int i = 1; i < occupancy; i++)
                    begin
                        slot_val[i-1]  = slot_val[i];
                        slot_prio[i-1] = slot_prio[i];
                    end
                    occupancy--;
                end
            end
            MODE_CLEAR:
            begin
                occupancy = 0;
            end
            default:
            begin
            end
        endcase
        rep.value = (occupancy > 0) ? slot_val[0]  : 32'sd0;
        rep.prio  = (occupancy > 0) ? slot_prio[0] : 32'sd0;
        rep.count = 5'(occupancy);
        rep.empty = (occupancy == 0);
        return rep;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        head_report_t want;
        if (!rst_n)
        begin
            occupancy = 0;
            fail_count = 0;
            pending_heads.delete();
            pending_count <= 0;
        end
        else
        begin
            // retire the response first: it always belongs to an older request
            if (rsp.valid && rsp.ready)
            begin
                if (pending_heads.size() == 0)
                begin
                    report_mismatch("response with no request outstanding",
                                    32'(rsp.entry_count), 32'd0);
                end
                else
                begin
                    want = pending_heads.pop_front();
                    if (rsp.head_value !== want.value)
                        report_mismatch("head_value", rsp.head_value, want.value);
                    if (rsp.head_priority !== want.prio)
                        report_mismatch("head_priority", rsp.head_priority, want.prio);
                    if (rsp.entry_count !== want.count)
                        report_mismatch("entry_count", 32'(rsp.entry_count), 32'(want.count));
                    if (rsp.queue_empty !== want.empty)
                        report_mismatch("queue_empty", 32'(rsp.queue_empty), 32'(want.empty));
                    if (rsp.dropped !== want.dropped)
                        report_mismatch("dropped", 32'(rsp.dropped), 32'(want.dropped));
                end
            end
            if (req.valid && req.ready)
                pending_heads.push_back(apply_request(req.mode, req.item_value,
                                                      req.item_priority));
            pending_count <= pending_heads.size();
        end
    end

endmodule

// ===== bench/tb_stable_priority_queue_top.sv =====
module tb_stable_priority_queue_top;
    import spq_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [1:0]         MODE_NOP     = 2'd3;
    localparam logic signed [31:0] PRIO_MAX     = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] PRIO_MIN     = 32'sh8000_0000;
    localparam int                 RANDOM_ITEMS = 1750;
    localparam int                 LONG_HOLD    = 300;
    localparam int                 CYCLE_LIMIT  = 250000;

    logic clk;
    logic rst_n;
    int   fail_count;
    int   pending_count;
    int   sent_count;
    int   cycle_count;

    spq_in_if  req_if ();
    spq_out_if rsp_if ();

    stable_priority_queue_top dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_if),
        .rsp   (rsp_if)
    );

    spq_checker u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .req           (req_if),
        .rsp           (rsp_if),
        .fail_count    (fail_count),
        .pending_count (pending_count)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("stable_priority_queue_top verification failed");
            $finish;
        end
    end

    task automatic send_request(input logic [1:0] m, input logic signed [31:0] v,
                                input logic signed [31:0] p);
        req_if.valid         <= 1'b1;
        req_if.mode          <= m;
        req_if.item_value    <= v;
        req_if.item_priority <= p;
        @(posedge clk);
        while (!req_if.ready)
            @(posedge clk);
        sent_count++;
    endtask

    // receiver: segments of steady, busy and sparse acceptance, plus one long hold-off
    initial
    begin
        int  seg_len;
        int  ready_pct;
        bit  held;
        held = 1'b0;
        rsp_if.ready <= 1'b0;
        forever
        begin
            if (!held && sent_count > 500)
            begin
                held = 1'b1;
                rsp_if.ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
            end
            seg_len = $urandom_range(5, 60);
            case ($urandom_range(2))
                0:       ready_pct = 100;
                1:       ready_pct = 70;
                default: ready_pct = 25;
            endcase
            repeat (seg_len)
            begin
                rsp_if.ready <= ($urandom_range(99) < ready_pct);
                @(posedge clk);
            end
        end
    end

    initial
    begin
        int                 random_sent;
        int                 seg_left;
        int                 enq_pct;
        int                 burst;
        int                 gap;
        int                 r;
        logic [1:0]         m;
        logic signed [31:0] p;

        sent_count           = 0;
        random_sent          = 0;
        seg_left             = 0;
        enq_pct              = 50;
        rst_n                <= 1'b0;
        req_if.valid         <= 1'b0;
        req_if.mode          <= MODE_ENQUEUE;
        req_if.item_value    <= 32'sd0;
        req_if.item_priority <= 32'sd0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty queue: dequeue, clear and the unused code all leave it empty
        send_request(MODE_DEQUEUE, 32'sd5, 32'sd5);
        send_request(MODE_CLEAR, 32'sd0, 32'sd0);
        send_request(MODE_NOP, 32'sd7, 32'sd7);
        // extremes and ties at both ends of the priority range
        send_request(MODE_ENQUEUE, 32'sh7FFF_FFFF, 32'sd0);
        send_request(MODE_ENQUEUE, 32'sh8000_0000, PRIO_MAX);
        send_request(MODE_ENQUEUE, -32'sd1, PRIO_MIN);
        send_request(MODE_ENQUEUE, 32'sd1, 32'sd0);
        send_request(MODE_ENQUEUE, 32'sd2, 32'sd0);
        send_request(MODE_ENQUEUE, 32'sd3, PRIO_MIN);
        send_request(MODE_ENQUEUE, 32'sd4, PRIO_MAX);
        for (int i = 0; i < 9; i++)
            send_request(MODE_ENQUEUE, 32'(i + 10), 32'(i % 3 - 1));
        // full: refused enqueue, then no-op, removal and clear
        send_request(MODE_ENQUEUE, 32'sh5A5A_5A5A, PRIO_MIN);
        send_request(MODE_NOP, 32'sd0, 32'sd0);
        send_request(MODE_DEQUEUE, 32'sd0, 32'sd0);
        send_request(MODE_DEQUEUE, 32'sd0, 32'sd0);
        send_request(MODE_CLEAR, 32'sd0, 32'sd0);
        send_request(MODE_DEQUEUE, 32'sd0, 32'sd0);

        // random part: segments lean towards filling, draining or neither so the queue sweeps its range
        while (random_sent < RANDOM_ITEMS)
        begin
            if (seg_left <= 0)
            begin
                seg_left = $urandom_range(20, 80);
                case ($urandom_range(3))
                    0:       enq_pct = 25;
                    1:       enq_pct = 50;
                    2:       enq_pct = 75;
                    default: enq_pct = 95;
                endcase
            end
            burst = $urandom_range(1, 16);
            repeat (burst)
            begin
                r = $urandom_range(99);
                if (r < 2)
                    m = MODE_NOP;
                else if (r < 5)
                    m = MODE_CLEAR;
                else if ($urandom_range(99) < enq_pct)
                    m = MODE_ENQUEUE;
                else
                    m = MODE_DEQUEUE;
                // narrow priorities give plenty of ties
                r = $urandom_range(99);
                if (r < 60)
                    p = $urandom_range(8) - 4;
                else if (r < 66)
                    p = r[0] ? PRIO_MAX : PRIO_MIN;
                else
                    p = $urandom;
                send_request(m, $urandom, p);
                random_sent++;
                seg_left--;
            end
            gap = $urandom_range(0, 9);
            if (gap >= 4)
            begin
                req_if.valid <= 1'b0;
                repeat (gap - 3) @(posedge clk);
            end
        end

        req_if.valid <= 1'b0;
        do
            @(posedge clk);
        while (pending_count != 0);
        repeat (4) @(posedge clk);
        if (fail_count == 0)
            $display("stable_priority_queue_top verification clean");
        else
            $display("stable_priority_queue_top verification failed");
        $finish;
    end

endmodule
